[hdl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared types and constants for the chained hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KeyBits     = 64;
  localparam int KeyBytes    = 8;
  localparam int LenBits     = 4;
  localparam int ValueBits   = 32;
  localparam int BucketBits  = 16;
  localparam int CfgBits     = 9;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam int AdlerShift  = 16;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_RETRIEVE = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [KeyBits-1:0]   key;
    logic [LenBits-1:0]   key_length;
    logic [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ValueBits-1:0] found_value;
  } rsp_t;

  // Classified job passed from the front part to the back part.
  typedef struct packed {
    logic [1:0]            kind;
    logic [KeyBits-1:0]    key;
    logic [LenBits-1:0]    key_length;
    logic [ValueBits-1:0]  value;
    logic [BucketBits-1:0] bucket;
  } job_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_HASH,
    FS_MOD,
    FS_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_HEAD,
    BS_WALK,
    BS_CMP
  } back_state_e;

endpackage

[hdl/cht_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cht_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the hashing front from the table back.
// ----------------------------------------------------------------------------
module cht_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cht_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cht_pkg::job_t pop_data_o,
  output logic          empty_o
);

  cht_pkg::job_t slot_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = slot_q[rd_q];

endmodule

[hdl/cht_front.sv]
// ----------------------------------------------------------------------------
// Hash front
// Accepts requests, hashes the key with Adler-32 one byte per cycle and
// reduces the hash modulo the bucket count two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cht_front #(
  parameter int BUCKETS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  cht_pkg::req_t                    req_i,
  input  logic [$clog2(BUCKETS+1)-1:0]     bc_i,
  output logic                             busy_o,
  output logic                             push_o,
  output cht_pkg::job_t                    job_o,
  input  logic                             full_i
);

  localparam int RW = $clog2(BUCKETS + 1);

  cht_pkg::front_state_e st_q, st_d;

  logic [1:0]                    kind_q, kind_d;
  logic [cht_pkg::KeyBits-1:0]   key_q, key_d;
  logic [cht_pkg::KeyBits-1:0]   sh_q, sh_d;
  logic [cht_pkg::LenBits-1:0]   len_q, len_d;
  logic [cht_pkg::ValueBits-1:0] val_q, val_d;
  logic [15:0]                   a_q, a_d;
  logic [15:0]                   b_q, b_d;
  logic [2:0]                    idx_q, idx_d;
  logic [31:0]                   div_q, div_d;
  logic [RW-1:0]                 rem_q, rem_d;
  logic [3:0]                    step_q, step_d;

  logic [cht_pkg::LenBits-1:0]   len_c;
  logic [cht_pkg::KeyBits-1:0]   key_m;
  logic [16:0]                   a_sum, b_sum;
  logic [15:0]                   a_n, b_n;
  logic [RW:0]                   r1, r2;
  logic [RW-1:0]                 r1s;

  // Clamp the length and drop key bytes beyond it.
  always_comb begin
    if (req_i.key_length == '0) begin
      len_c = cht_pkg::LenBits'(1);
    end else if (req_i.key_length > cht_pkg::LenBits'(cht_pkg::KeyBytes)) begin
      len_c = cht_pkg::LenBits'(cht_pkg::KeyBytes);
    end else begin
      len_c = req_i.key_length;
    end
    for (int i = 0; i < cht_pkg::KeyBytes; i++) begin
      key_m[8*i +: 8] = (cht_pkg::LenBits'(i) < len_c) ? req_i.key[8*i +: 8] : 8'h00;
    end
  end

  // One Adler-32 byte step; both sums stay below twice the modulus.
  always_comb begin
    a_sum = {1'b0, a_q} + {9'd0, sh_q[7:0]};
    a_n   = (a_sum >= cht_pkg::AdlerMod) ? 16'(a_sum - cht_pkg::AdlerMod) : a_sum[15:0];
    b_sum = {1'b0, b_q} + {1'b0, a_n};
    b_n   = (b_sum >= cht_pkg::AdlerMod) ? 16'(b_sum - cht_pkg::AdlerMod) : b_sum[15:0];
  end

  // Two restoring remainder steps per cycle.
  always_comb begin
    r1  = {rem_q, div_q[31]};
    if (r1 >= {1'b0, bc_i}) begin
      r1 = r1 - {1'b0, bc_i};
    end
    r1s = r1[RW-1:0];
    r2  = {r1s, div_q[30]};
    if (r2 >= {1'b0, bc_i}) begin
      r2 = r2 - {1'b0, bc_i};
    end
  end

  always_comb begin
    st_d   = st_q;
    kind_d = kind_q;
    key_d  = key_q;
    sh_d   = sh_q;
    len_d  = len_q;
    val_d  = val_q;
    a_d    = a_q;
    b_d    = b_q;
    idx_d  = idx_q;
    div_d  = div_q;
    rem_d  = rem_q;
    step_d = step_q;
    push_o = 1'b0;
    unique case (st_q)
      cht_pkg::FS_IDLE: begin
        if (accept_i) begin
          kind_d = req_i.kind;
          key_d  = key_m;
          sh_d   = key_m;
          len_d  = len_c;
          val_d  = req_i.value;
          a_d    = 16'd1;
          b_d    = 16'd0;
          idx_d  = 3'd0;
          st_d   = cht_pkg::FS_HASH;
        end
      end
      cht_pkg::FS_HASH: begin
        a_d   = a_n;
        b_d   = b_n;
        sh_d  = sh_q >> 8;
        idx_d = idx_q + 3'd1;
        if ({1'b0, idx_q} == len_q - cht_pkg::LenBits'(1)) begin
          div_d  = {b_n, a_n};
          rem_d  = '0;
          step_d = 4'd0;
          st_d   = cht_pkg::FS_MOD;
        end
      end
      cht_pkg::FS_MOD: begin
        div_d  = div_q << 2;
        rem_d  = r2[RW-1:0];
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          st_d = cht_pkg::FS_PUSH;
        end
      end
      cht_pkg::FS_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          st_d   = cht_pkg::FS_IDLE;
        end
      end
      default: st_d = cht_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cht_pkg::FS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    key_q  <= key_d;
    sh_q   <= sh_d;
    len_q  <= len_d;
    val_q  <= val_d;
    a_q    <= a_d;
    b_q    <= b_d;
    idx_q  <= idx_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

  assign busy_o            = (st_q != cht_pkg::FS_IDLE);
  assign job_o.kind        = kind_q;
  assign job_o.key         = key_q;
  assign job_o.key_length  = len_q;
  assign job_o.value       = val_q;
  assign job_o.bucket      = cht_pkg::BucketBits'(rem_q);

endmodule

[hdl/cht_back.sv]
// ----------------------------------------------------------------------------
// Table back
// Executes queued jobs against the bucket heads, the entry pool and the
// free stack, and issues one result strobe per job.
// ----------------------------------------------------------------------------
module cht_back #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  cht_pkg::job_t job_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          done_o,
  output cht_pkg::rsp_t rsp_o
);

  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IW   = $clog2(ENTRIES);
  localparam int LW   = IW + 1;
  localparam int MAXN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CW   = $clog2(MAXN);
  localparam int EW   = cht_pkg::KeyBits + cht_pkg::LenBits + cht_pkg::ValueBits;
  localparam logic [LW-1:0] Nil = LW'(ENTRIES);

  cht_pkg::back_state_e st_q, st_d;

  cht_pkg::job_t job_q, job_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [IW-1:0] e_q, e_d;
  logic [LW-1:0] fc_q, fc_d;
  logic [CW-1:0] clr_q, clr_d;
  logic          done_q, done_d;
  cht_pkg::rsp_t rsp_q, rsp_d;

  logic          head_we;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [LW-1:0] head_wdata, head_rdata;
  logic          ent_we;
  logic [IW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic          nxt_we;
  logic [IW-1:0] nxt_waddr, nxt_raddr;
  logic [LW-1:0] nxt_wdata, nxt_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [IW-1:0] stk_wdata, stk_rdata;

  logic [cht_pkg::KeyBits-1:0]   ent_key;
  logic [cht_pkg::LenBits-1:0]   ent_len;
  logic [cht_pkg::ValueBits-1:0] ent_val;

  assign ent_key = ent_rdata[EW-1 -: cht_pkg::KeyBits];
  assign ent_len = ent_rdata[cht_pkg::ValueBits +: cht_pkg::LenBits];
  assign ent_val = ent_rdata[cht_pkg::ValueBits-1:0];

  cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  cht_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );
  cht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(nxt_raddr), .rdata_o(nxt_rdata)
  );
  cht_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  always_comb begin
    st_d       = st_q;
    job_d      = job_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    e_d        = e_q;
    fc_d       = fc_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    pop_o      = 1'b0;
    head_we    = 1'b0;
    head_waddr = job_q.bucket[BW-1:0];
    head_wdata = Nil;
    head_raddr = job_i.bucket[BW-1:0];
    ent_we     = 1'b0;
    ent_waddr  = stk_rdata;
    ent_wdata  = {job_q.key, job_q.key_length, job_q.value};
    ent_raddr  = head_rdata[IW-1:0];
    nxt_we     = 1'b0;
    nxt_waddr  = stk_rdata;
    nxt_wdata  = Nil;
    nxt_raddr  = head_rdata[IW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = fc_q[IW-1:0];
    stk_wdata  = cur_q[IW-1:0];
    stk_raddr  = fc_q[IW-1:0] - IW'(1);
    unique case (st_q)
      cht_pkg::BS_CLEAR: begin
        head_we    = ({1'b0, clr_q} < (CW+1)'(BUCKETS));
        head_waddr = BW'(clr_q);
        head_wdata = Nil;
        stk_we     = ({1'b0, clr_q} < (CW+1)'(ENTRIES));
        stk_waddr  = IW'(clr_q);
        stk_wdata  = IW'(clr_q);
        clr_d      = clr_q + CW'(1);
        if (clr_q == CW'(MAXN - 1)) begin
          st_d = cht_pkg::BS_IDLE;
        end
      end
      cht_pkg::BS_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          st_d  = cht_pkg::BS_HEAD;
        end
      end
      cht_pkg::BS_HEAD: begin
        cur_d  = head_rdata;
        prev_d = Nil;
        st_d   = cht_pkg::BS_IDLE;
        rsp_d.found_value = '0;
        unique case (job_q.kind) inside
          cht_pkg::KIND_INSERT: begin
            done_d = 1'b1;
            if (fc_q == '0) begin
              rsp_d.status = cht_pkg::ST_FULL;
            end else begin
              ent_we = 1'b1;
              nxt_we = 1'b1;
              fc_d   = fc_q - LW'(1);
              e_d    = stk_rdata;
              if (head_rdata >= Nil) begin
                head_we      = 1'b1;
                head_wdata   = {1'b0, stk_rdata};
                rsp_d.status = cht_pkg::ST_OK;
              end else begin
                done_d = 1'b0;
                st_d   = cht_pkg::BS_WALK;
              end
            end
          end
          cht_pkg::KIND_RETRIEVE, cht_pkg::KIND_DELETE: begin
            if (head_rdata >= Nil) begin
              done_d       = 1'b1;
              rsp_d.status = cht_pkg::ST_NOT_FOUND;
            end else begin
              st_d = cht_pkg::BS_CMP;
            end
          end
          default: begin
            done_d       = 1'b1;
            rsp_d.status = cht_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      cht_pkg::BS_WALK: begin
        nxt_raddr = nxt_rdata[IW-1:0];
        if (nxt_rdata >= Nil) begin
          nxt_we       = 1'b1;
          nxt_waddr    = cur_q[IW-1:0];
          nxt_wdata    = {1'b0, e_q};
          done_d       = 1'b1;
          rsp_d.status = cht_pkg::ST_OK;
          st_d         = cht_pkg::BS_IDLE;
        end else begin
          cur_d = nxt_rdata;
        end
      end
      cht_pkg::BS_CMP: begin
        ent_raddr = nxt_rdata[IW-1:0];
        nxt_raddr = nxt_rdata[IW-1:0];
        if (ent_len == job_q.key_length && ent_key == job_q.key) begin
          done_d       = 1'b1;
          rsp_d.status = cht_pkg::ST_OK;
          st_d         = cht_pkg::BS_IDLE;
          if (job_q.kind == cht_pkg::KIND_RETRIEVE) begin
            rsp_d.found_value = ent_val;
          end else begin
            if (prev_q >= Nil) begin
              head_we    = 1'b1;
              head_wdata = nxt_rdata;
            end else begin
              nxt_we    = 1'b1;
              nxt_waddr = prev_q[IW-1:0];
              nxt_wdata = nxt_rdata;
            end
            if (fc_q < Nil) begin
              stk_we = 1'b1;
              fc_d   = fc_q + LW'(1);
            end
          end
        end else if (nxt_rdata >= Nil) begin
          done_d       = 1'b1;
          rsp_d.status = cht_pkg::ST_NOT_FOUND;
          st_d         = cht_pkg::BS_IDLE;
        end else begin
          prev_d = cur_q;
          cur_d  = nxt_rdata;
        end
      end
      default: st_d = cht_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= cht_pkg::BS_CLEAR;
      fc_q   <= Nil;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      fc_q   <= fc_d;
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    e_q    <= e_d;
    rsp_q  <= rsp_d;
  end

  assign clearing_o = (st_q == cht_pkg::BS_CLEAR);
  assign done_o     = done_q;
  assign rsp_o      = rsp_q;

endmodule

[hdl/chained_hash_table_engine_core.sv]
// ----------------------------------------------------------------------------
// Chained hash table engine
// Insert, retrieve and delete on a separately chained hash table with an
// Adler-32 bucket hash.
// ----------------------------------------------------------------------------
// A request is hashed byte by byte, reduced by the remainder unit and pushed
// into the queue; the back part then executes it, visiting chain entries one
// by one, and strobes done. The front takes a new transfer only once it has
// pushed the last job, while the back part may still be executing it; a long
// chain fills the queue and holds the front, and busy stays high until it has room.
// After reset the engine holds busy high while the bucket heads and the free
// stack are initialized. Results are strobed for one cycle and the receiver
// cannot stall them.
module chained_hash_table_engine_core #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  cht_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic [cht_pkg::CfgBits-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output cht_pkg::rsp_t                 rsp_o
);

  localparam int RW = $clog2(BUCKETS + 1);

  // Bucket count register, clamped to 1..BUCKETS where it is used.
  logic [cht_pkg::CfgBits-1:0] bc_q;
  logic [RW-1:0]               bc_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= cht_pkg::CfgBits'(256);
    end else if (cfg_we_i) begin
      bc_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (bc_q == '0) begin
      bc_eff = RW'(1);
    end else if (32'(bc_q) > 32'(BUCKETS)) begin
      bc_eff = RW'(BUCKETS);
    end else begin
      bc_eff = RW'(bc_q);
    end
  end

  logic          front_busy;
  logic          clearing;
  logic          accept;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  cht_pkg::job_t front_job;
  cht_pkg::job_t back_job;

  // A transfer is taken only while both the hash front and the reset sweep
  // are idle.
  assign busy   = front_busy | clearing;
  assign accept = start & ~busy;

  cht_front #(.BUCKETS(BUCKETS)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i(accept),
    .req_i,
    .bc_i    (bc_eff),
    .busy_o  (front_busy),
    .push_o  (push),
    .job_o   (front_job),
    .full_i  (q_full)
  );

  // The queue lets the next key hash while the back part walks a chain.
  cht_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_data_i(front_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_data_o (back_job),
    .empty_o    (q_empty)
  );

  cht_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
    .clk_i,
    .rst_ni,
    .empty_i   (q_empty),
    .job_i     (back_job),
    .pop_o     (pop),
    .clearing_o(clearing),
    .done_o,
    .rsp_o
  );

endmodule
